/* rtl/rvcexec_pkg.sv */
// ----------------------------------------------------------------------------
// rvcexec_pkg
// Shared types, encodings and read-port address decode for the RV32C executor.
// ----------------------------------------------------------------------------
`default_nettype none

package rvcexec_pkg;

    // Widths
    localparam int XLEN   = 32;
    localparam int IW     = 16;
    localparam int RIDX_W = 5;
    localparam int NREGS  = 32;

    // Request kinds
    localparam logic REQ_EXEC     = 1'b0;
    localparam logic REQ_LOAD_RET = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNHANDLED = 2'd1;
    localparam logic [1:0] ST_HINT      = 2'd2;

    // Quadrants (instr[1:0])
    localparam logic [1:0] Q0 = 2'b00;
    localparam logic [1:0] Q1 = 2'b01;
    localparam logic [1:0] Q2 = 2'b10;

    // Quadrant 0 funct3
    localparam logic [2:0] F3_ADDI4SPN = 3'b000;
    localparam logic [2:0] F3_LW       = 3'b010;
    localparam logic [2:0] F3_SW       = 3'b110;

    // Quadrant 1 funct3
    localparam logic [2:0] F3_ADDI = 3'b000;
    localparam logic [2:0] F3_JAL  = 3'b001;
    localparam logic [2:0] F3_LI   = 3'b010;
    localparam logic [2:0] F3_LUI  = 3'b011;
    localparam logic [2:0] F3_MISC = 3'b100;
    localparam logic [2:0] F3_J    = 3'b101;
    localparam logic [2:0] F3_BEQZ = 3'b110;
    localparam logic [2:0] F3_BNEZ = 3'b111;

    // Quadrant 2 funct3
    localparam logic [2:0] F3_SLLI = 3'b000;
    localparam logic [2:0] F3_LWSP = 3'b010;
    localparam logic [2:0] F3_JR   = 3'b100;
    localparam logic [2:0] F3_SWSP = 3'b110;

    // Quadrant 1 misc-ALU funct2 (instr[11:10])
    localparam logic [1:0] FN2_SRLI  = 2'b00;
    localparam logic [1:0] FN2_SRAI  = 2'b01;
    localparam logic [1:0] FN2_ANDI  = 2'b10;
    localparam logic [1:0] FN2_ARITH = 2'b11;

    // Register-register ops (instr[6:5])
    localparam logic [1:0] AR_SUB = 2'b00;
    localparam logic [1:0] AR_XOR = 2'b01;
    localparam logic [1:0] AR_OR  = 2'b10;
    localparam logic [1:0] AR_AND = 2'b11;

    // Architectural register numbers
    localparam logic [RIDX_W-1:0] REG_ZERO = 5'd0;
    localparam logic [RIDX_W-1:0] REG_RA   = 5'd1;
    localparam logic [RIDX_W-1:0] REG_SP   = 5'd2;

    // Compressed register field base (x8)
    localparam logic [1:0] CREG_BASE = 2'b01;

    typedef struct packed {
        logic            req_type;
        logic [IW-1:0]   instr;
        logic [XLEN-1:0] pc;
        logic [XLEN-1:0] load_data;
    } t_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [XLEN-1:0]   next_pc;
        logic              mem_read;
        logic              mem_write;
        logic [XLEN-1:0]   mem_addr;
        logic [XLEN-1:0]   mem_wdata;
        logic              wb_enable;
        logic [RIDX_W-1:0] wb_index;
        logic [XLEN-1:0]   wb_value;
    } t_result;

    typedef struct packed {
        logic              en;
        logic [RIDX_W-1:0] idx;
        logic [XLEN-1:0]   val;
    } t_wb;

    // Read port A: the base / first source operand
    function automatic logic [RIDX_W-1:0] rd_addr_a(input logic [IW-1:0] instr);
        logic [RIDX_W-1:0] a;
        a = {CREG_BASE, instr[9:7]};
        case (instr[1:0])
            Q0: begin
                if (instr[15:13] == F3_ADDI4SPN) a = REG_SP;
            end
            Q1: begin
                if (instr[15:13] == F3_ADDI) a = instr[11:7];
                else if (instr[15:13] == F3_LUI) a = REG_SP;
            end
            Q2: begin
                if (instr[15:13] == F3_LWSP || instr[15:13] == F3_SWSP) a = REG_SP;
                else a = instr[11:7];
            end
            default: a = {CREG_BASE, instr[9:7]};
        endcase
        return a;
    endfunction

    // Read port B: second source / store data
    function automatic logic [RIDX_W-1:0] rd_addr_b(input logic [IW-1:0] instr);
        logic [RIDX_W-1:0] b;
        if (instr[1:0] == Q2) b = instr[6:2];
        else b = {CREG_BASE, instr[4:2]};
        return b;
    endfunction

endpackage

`default_nettype wire

/* rtl/rvcexec_in_if.sv */
// ----------------------------------------------------------------------------
// rvcexec_in_if
// Request channel: instruction or load-data return, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rvcexec_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] instr;
    logic [31:0] pc;
    logic [31:0] load_data;

    modport source (output valid, req_type, instr, pc, load_data, input ready);
    modport sink   (input valid, req_type, instr, pc, load_data, output ready);
endinterface

`default_nettype wire

/* rtl/rvcexec_out_if.sv */
// ----------------------------------------------------------------------------
// rvcexec_out_if
// Result channel: status, next pc, memory request and writeback report.
// ----------------------------------------------------------------------------
`default_nettype none

interface rvcexec_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] next_pc;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] mem_addr;
    logic [31:0] mem_wdata;
    logic        wb_enable;
    logic [4:0]  wb_index;
    logic [31:0] wb_value;

    modport source (output valid, status, next_pc, mem_read, mem_write, mem_addr,
                    mem_wdata, wb_enable, wb_index, wb_value, input ready);
    modport sink   (input valid, status, next_pc, mem_read, mem_write, mem_addr,
                    mem_wdata, wb_enable, wb_index, wb_value, output ready);
endinterface

`default_nettype wire

/* rtl/rvcexec_regfile.sv */
// ----------------------------------------------------------------------------
// rvcexec_regfile
// 32 x 32 integer register file, two registered read ports, one write port,
// per-entry valid bits for reset-to-zero and write-to-read bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module rvcexec_regfile (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_rd_en,
    input  wire  [rvcexec_pkg::RIDX_W-1:0]  i_rd_addr_a,
    input  wire  [rvcexec_pkg::RIDX_W-1:0]  i_rd_addr_b,
    input  wire  rvcexec_pkg::t_wb          i_wb,
    output logic [rvcexec_pkg::XLEN-1:0]    o_rd_data_a,
    output logic [rvcexec_pkg::XLEN-1:0]    o_rd_data_b
);

    logic [rvcexec_pkg::XLEN-1:0]  mem [rvcexec_pkg::NREGS];
    logic [rvcexec_pkg::NREGS-1:0] r_valid;
    logic [rvcexec_pkg::XLEN-1:0]  r_raw_a, r_raw_b;
    logic                          r_vld_a, r_vld_b;
    logic                          r_byp_a, r_byp_b;
    logic [rvcexec_pkg::XLEN-1:0]  r_byp_val;

    // Storage write (x0 never written: caller gates en)
    always_ff @(posedge i_clk) begin
        if (i_wb.en) begin
            mem[i_wb.idx] <= i_wb.val;
        end
    end

    // Registered reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_raw_a <= mem[i_rd_addr_a];
            r_raw_b <= mem[i_rd_addr_b];
        end
    end

    // Valid bits: entry reads as zero until first write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wb.en) begin
            r_valid[i_wb.idx] <= 1'b1;
        end
    end

    // Valid and bypass flags sampled with the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_byp_a <= 1'b0;
            r_byp_b <= 1'b0;
        end else if (i_rd_en) begin
            r_vld_a <= r_valid[i_rd_addr_a];
            r_vld_b <= r_valid[i_rd_addr_b];
            r_byp_a <= i_wb.en && (i_wb.idx == i_rd_addr_a);
            r_byp_b <= i_wb.en && (i_wb.idx == i_rd_addr_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byp_val <= i_wb.val;
        end
    end

    // Read data select
    always_comb begin
        if (r_byp_a) o_rd_data_a = r_byp_val;
        else if (r_vld_a) o_rd_data_a = r_raw_a;
        else o_rd_data_a = '0;
        if (r_byp_b) o_rd_data_b = r_byp_val;
        else if (r_vld_b) o_rd_data_b = r_raw_b;
        else o_rd_data_b = '0;
    end

endmodule

`default_nettype wire

/* rtl/rvcexec_exec.sv */
// ----------------------------------------------------------------------------
// rvcexec_exec
// Decode and execute of one compressed instruction or load-data return,
// plus the pending-load tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module rvcexec_exec (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_fire,
    input  wire  rvcexec_pkg::t_item      i_item,
    input  wire  [rvcexec_pkg::XLEN-1:0]  i_ra,
    input  wire  [rvcexec_pkg::XLEN-1:0]  i_rb,
    output rvcexec_pkg::t_result          o_res
);

    localparam int XL = rvcexec_pkg::XLEN;
    localparam int RW = rvcexec_pkg::RIDX_W;

    logic            r_pend, n_pend;
    logic [RW-1:0]   r_dest, n_dest;

    logic [15:0]     ins;
    logic [XL-1:0]   pc, pc2;
    logic [1:0]      op;
    logic [2:0]      f3;
    logic [RW-1:0]   rdf, rs2f, rdp, rs1p;
    logic            b12;
    logic [XL-1:0]   ci6;
    logic [9:0]      u_4spn;
    logic [6:0]      u_lw;
    logic [7:0]      u_lwsp, u_swsp;
    logic [XL-1:0]   s_jmp, s_16sp, s_br;

    logic [1:0]      st;
    logic [XL-1:0]   nxt;
    logic            mrd, mwr;
    logic [XL-1:0]   maddr, mwd;
    logic            wreq;
    logic [RW-1:0]   widx;
    logic [XL-1:0]   wval;
    logic            wen;

    // Field extraction
    assign ins  = i_item.instr;
    assign pc   = i_item.pc;
    assign pc2  = pc + XL'(2);
    assign op   = ins[1:0];
    assign f3   = ins[15:13];
    assign rdf  = ins[11:7];
    assign rs2f = ins[6:2];
    assign rdp  = {rvcexec_pkg::CREG_BASE, ins[4:2]};
    assign rs1p = {rvcexec_pkg::CREG_BASE, ins[9:7]};
    assign b12  = ins[12];

    // Immediates
    assign ci6    = {{26{ins[12]}}, ins[12], ins[6:2]};
    assign u_4spn = {ins[10:7], ins[12:11], ins[5], ins[6], 2'b00};
    assign u_lw   = {ins[5], ins[12:10], ins[6], 2'b00};
    assign u_lwsp = {ins[3:2], ins[12], ins[6:4], 2'b00};
    assign u_swsp = {ins[8:7], ins[12:9], 2'b00};
    assign s_jmp  = {{21{ins[12]}}, ins[8], ins[10:9], ins[6], ins[7], ins[2], ins[11],
                     ins[5:3], 1'b0};
    assign s_16sp = {{23{ins[12]}}, ins[4:3], ins[5], ins[2], ins[6], 4'b0000};
    assign s_br   = {{24{ins[12]}}, ins[6:5], ins[2], ins[11:10], ins[4:3], 1'b0};

    // Execute
    always_comb begin
        st     = rvcexec_pkg::ST_OK;
        nxt    = pc2;
        mrd    = 1'b0;
        mwr    = 1'b0;
        maddr  = '0;
        mwd    = '0;
        wreq   = 1'b0;
        widx   = rvcexec_pkg::REG_ZERO;
        wval   = '0;
        n_pend = r_pend;
        n_dest = r_dest;

        if (i_item.req_type == rvcexec_pkg::REQ_LOAD_RET) begin
            // Load data return
            nxt = '0;
            if (r_pend) begin
                wreq   = 1'b1;
                widx   = r_dest;
                wval   = i_item.load_data;
                n_pend = 1'b0;
            end else begin
                st = rvcexec_pkg::ST_UNHANDLED;
            end
        end else begin
            case (op)
                rvcexec_pkg::Q0: begin
                    case (f3)
                        rvcexec_pkg::F3_ADDI4SPN: begin
                            if (u_4spn == '0) begin
                                st = rvcexec_pkg::ST_UNHANDLED;
                            end else begin
                                wreq = 1'b1;
                                widx = rdp;
                                wval = i_ra + XL'(u_4spn);
                            end
                        end
                        rvcexec_pkg::F3_LW: begin
                            maddr  = i_ra + XL'(u_lw);
                            mrd    = 1'b1;
                            n_pend = 1'b1;
                            n_dest = rdp;
                        end
                        rvcexec_pkg::F3_SW: begin
                            maddr = i_ra + XL'(u_lw);
                            mwr   = 1'b1;
                            mwd   = i_rb;
                        end
                        default: st = rvcexec_pkg::ST_UNHANDLED;
                    endcase
                end
                rvcexec_pkg::Q1: begin
                    case (f3)
                        rvcexec_pkg::F3_ADDI: begin
                            wreq = 1'b1;
                            widx = rdf;
                            wval = i_ra + ci6;
                        end
                        rvcexec_pkg::F3_JAL: begin
                            nxt  = pc + s_jmp;
                            wreq = 1'b1;
                            widx = rvcexec_pkg::REG_RA;
                            wval = pc2;
                        end
                        rvcexec_pkg::F3_J: begin
                            nxt = pc + s_jmp;
                        end
                        rvcexec_pkg::F3_LI: begin
                            if (rdf == rvcexec_pkg::REG_ZERO) begin
                                st = rvcexec_pkg::ST_UNHANDLED;
                            end else begin
                                wreq = 1'b1;
                                widx = rdf;
                                wval = ci6;
                            end
                        end
                        rvcexec_pkg::F3_LUI: begin
                            if (rdf == rvcexec_pkg::REG_SP) begin
                                // c.addi16sp
                                if (s_16sp == '0) begin
                                    st = rvcexec_pkg::ST_UNHANDLED;
                                end else begin
                                    wreq = 1'b1;
                                    widx = rvcexec_pkg::REG_SP;
                                    wval = i_ra + s_16sp;
                                end
                            end else if (rdf == rvcexec_pkg::REG_ZERO ||
                                         (!b12 && rs2f == '0)) begin
                                st = rvcexec_pkg::ST_UNHANDLED;
                            end else begin
                                wreq = 1'b1;
                                widx = rdf;
                                wval = {ci6[19:0], 12'h000};
                            end
                        end
                        rvcexec_pkg::F3_MISC: begin
                            case (ins[11:10])
                                rvcexec_pkg::FN2_SRLI, rvcexec_pkg::FN2_SRAI: begin
                                    if (b12 || rs2f == '0) begin
                                        st = rvcexec_pkg::ST_UNHANDLED;
                                    end else begin
                                        wreq = 1'b1;
                                        widx = rs1p;
                                        if (ins[10]) wval = XL'($signed(i_ra) >>> rs2f);
                                        else wval = i_ra >> rs2f;
                                    end
                                end
                                rvcexec_pkg::FN2_ANDI: begin
                                    wreq = 1'b1;
                                    widx = rs1p;
                                    wval = i_ra & ci6;
                                end
                                default: begin
                                    if (b12) begin
                                        st = rvcexec_pkg::ST_UNHANDLED;
                                    end else begin
                                        wreq = 1'b1;
                                        widx = rs1p;
                                        case (ins[6:5])
                                            rvcexec_pkg::AR_SUB: wval = i_ra - i_rb;
                                            rvcexec_pkg::AR_XOR: wval = i_ra ^ i_rb;
                                            rvcexec_pkg::AR_OR:  wval = i_ra | i_rb;
                                            default:             wval = i_ra & i_rb;
                                        endcase
                                    end
                                end
                            endcase
                        end
                        rvcexec_pkg::F3_BEQZ, rvcexec_pkg::F3_BNEZ: begin
                            if ((i_ra == '0) == (f3 == rvcexec_pkg::F3_BEQZ)) begin
                                nxt = pc + s_br;
                            end
                        end
                        default: st = rvcexec_pkg::ST_UNHANDLED;
                    endcase
                end
                rvcexec_pkg::Q2: begin
                    case (f3)
                        rvcexec_pkg::F3_SLLI: begin
                            if (rdf == rvcexec_pkg::REG_ZERO) begin
                                st = rvcexec_pkg::ST_HINT;
                            end else if (b12) begin
                                st = rvcexec_pkg::ST_UNHANDLED;
                            end else begin
                                wreq = 1'b1;
                                widx = rdf;
                                wval = i_ra << rs2f;
                            end
                        end
                        rvcexec_pkg::F3_LWSP: begin
                            if (rdf == rvcexec_pkg::REG_ZERO) begin
                                st = rvcexec_pkg::ST_UNHANDLED;
                            end else begin
                                maddr  = i_ra + XL'(u_lwsp);
                                mrd    = 1'b1;
                                n_pend = 1'b1;
                                n_dest = rdf;
                            end
                        end
                        rvcexec_pkg::F3_JR: begin
                            if (rdf == rvcexec_pkg::REG_ZERO) begin
                                // includes c.ebreak
                                st = rvcexec_pkg::ST_UNHANDLED;
                            end else if (rs2f == '0) begin
                                // c.jr / c.jalr, rs1 read before x1 write
                                nxt = {i_ra[XL-1:1], 1'b0};
                                if (b12) begin
                                    wreq = 1'b1;
                                    widx = rvcexec_pkg::REG_RA;
                                    wval = pc2;
                                end
                            end else begin
                                wreq = 1'b1;
                                widx = rdf;
                                wval = b12 ? (i_ra + i_rb) : i_rb;
                            end
                        end
                        rvcexec_pkg::F3_SWSP: begin
                            maddr = i_ra + XL'(u_swsp);
                            mwr   = 1'b1;
                            mwd   = i_rb;
                        end
                        default: st = rvcexec_pkg::ST_UNHANDLED;
                    endcase
                end
                default: st = rvcexec_pkg::ST_UNHANDLED;
            endcase
        end
    end

    // Writeback report, x0 writes dropped
    assign wen = wreq && (widx != rvcexec_pkg::REG_ZERO);

    always_comb begin
        o_res.status    = st;
        o_res.next_pc   = nxt;
        o_res.mem_read  = mrd;
        o_res.mem_write = mwr;
        o_res.mem_addr  = maddr;
        o_res.mem_wdata = mwd;
        o_res.wb_enable = wen;
        o_res.wb_index  = wen ? widx : rvcexec_pkg::REG_ZERO;
        o_res.wb_value  = wen ? wval : '0;
    end

    // Pending load tracker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_dest <= rvcexec_pkg::REG_ZERO;
        end else if (i_fire) begin
            r_pend <= n_pend;
            r_dest <= n_dest;
        end
    end

endmodule

`default_nettype wire

/* rtl/rv32c_compressed_executor_unit.sv */
// ----------------------------------------------------------------------------
// rv32c_compressed_executor_unit
// RV32C compressed instruction executor with a 32-entry integer register file.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-------------------------------------------
//   i_in     | in  | valid / ready | req_type, instr, pc, load_data
//   o_out    | out | valid / ready | status, next_pc, mem_*, wb_*
//
// One item per cycle sustained while o_out accepts results; a result passes the
// register file read stage, then execute into the result register, and holds
// there until it transfers.
// Back-to-back register dependences are covered by the write bypass in the
// register file read path.
// Reset: synchronous; register file reads zero via per-entry valid bits, so
// items are taken as soon as reset is released, with no clearing pass.
// A stalled result holds; one more item is taken into the read stage, then
// ready drops until the result transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32c_compressed_executor_unit (
    input  wire           i_clk,
    input  wire           i_rst_n,
    rvcexec_in_if.sink    i_in,
    rvcexec_out_if.source o_out
);

    logic                         in_acc;
    logic                         fire_b;
    logic                         r_a_valid;
    rvcexec_pkg::t_item           r_a_item, in_item;
    logic                         r_out_valid;
    rvcexec_pkg::t_result         r_out, res;
    rvcexec_pkg::t_wb             wb;
    logic [rvcexec_pkg::XLEN-1:0] ra, rb;

    // Handshake and stage advance
    assign fire_b     = r_a_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_a_valid || fire_b;
    assign in_acc     = i_in.valid && i_in.ready;

    assign in_item.req_type  = i_in.req_type;
    assign in_item.instr     = i_in.instr;
    assign in_item.pc        = i_in.pc;
    assign in_item.load_data = i_in.load_data;

    // Read stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc) begin
            r_a_valid <= 1'b1;
        end else if (fire_b) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_item <= in_item;
        end
    end

    // Register file write from the executing item
    assign wb.en  = fire_b && res.wb_enable;
    assign wb.idx = res.wb_index;
    assign wb.val = res.wb_value;

    rvcexec_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_acc),
        .i_rd_addr_a (rvcexec_pkg::rd_addr_a(i_in.instr)),
        .i_rd_addr_b (rvcexec_pkg::rd_addr_b(i_in.instr)),
        .i_wb        (wb),
        .o_rd_data_a (ra),
        .o_rd_data_b (rb)
    );

    rvcexec_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire_b),
        .i_item  (r_a_item),
        .i_ra    (ra),
        .i_rb    (rb),
        .o_res   (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire_b) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_b) begin
            r_out <= res;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out.status;
    assign o_out.next_pc   = r_out.next_pc;
    assign o_out.mem_read  = r_out.mem_read;
    assign o_out.mem_write = r_out.mem_write;
    assign o_out.mem_addr  = r_out.mem_addr;
    assign o_out.mem_wdata = r_out.mem_wdata;
    assign o_out.wb_enable = r_out.wb_enable;
    assign o_out.wb_index  = r_out.wb_index;
    assign o_out.wb_value  = r_out.wb_value;

`ifndef SYNTHESIS
    // x0 is never reported as written
    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.wb_enable && r_out.wb_index == rvcexec_pkg::REG_ZERO))
        else $error("writeback to x0 reported");

    // a rejected form leaves no side effects
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != rvcexec_pkg::ST_OK) |->
        (!r_out.wb_enable && !r_out.mem_read && !r_out.mem_write))
        else $error("side effect on rejected item");

    // never a read and a write request together
    a_one_mem_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.mem_read && r_out.mem_write))
        else $error("read and write request together");

    // a held read-stage item advances once the result register frees
    a_stage_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !r_out_valid) |-> fire_b)
        else $error("read stage stuck with empty result register");
`endif

endmodule

`default_nettype wire

/* bench/rv32c_compressed_executor_unit_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32c_compressed_executor_unit_check
// Watches the request and result channels of the RV32C executor. It keeps its
// own register file and load tracking, works out the result of every
// transferred request and compares each transferred result with the oldest
// outstanding prediction, field by field.
// ----------------------------------------------------------------------------

module rv32c_compressed_executor_unit_check (
    input  wire    i_clk,
    input  wire    i_rst_n,
    rvcexec_in_if  i_req,
    rvcexec_out_if i_res,
    output int     o_mismatch_count,
    output int     o_outstanding
);

    import rvcexec_pkg::*;

    // Architectural state as the executor should hold it
    logic [XLEN-1:0]   xreg [NREGS];
    logic              load_busy;
    logic [RIDX_W-1:0] load_rd;

    t_result outcome;
    t_result retire_queue [$];
    int      mismatches = 0;

    // Register write with the x0 rule; also reported in the result
    function automatic void record_write(input logic [RIDX_W-1:0] idx,
                                         input logic [XLEN-1:0] val);
        if (idx != REG_ZERO) begin
            xreg[idx]         = val;
            outcome.wb_enable = 1'b1;
            outcome.wb_index  = idx;
            outcome.wb_value  = val;
        end
    endfunction

    // Predicts the result of one request and updates the state
    function automatic void retire_item(input t_item it);
        logic [IW-1:0]     i;
        logic [XLEN-1:0]   pc, ci6, u, v, w;
        logic [2:0]        f3;
        logic [RIDX_W-1:0] rdf, rs2f, rdp, rs1p;
        outcome = '0;
        outcome.status = ST_OK;

        // load data return
        if (it.req_type == REQ_LOAD_RET) begin
            if (load_busy) begin
                record_write(load_rd, it.load_data);
                load_busy = 1'b0;
            end else begin
                outcome.status = ST_UNHANDLED;
            end
            return;
        end

        i    = it.instr;
        pc   = it.pc;
        f3   = i[15:13];
        rdf  = i[11:7];
        rs2f = i[6:2];
        rdp  = {CREG_BASE, i[4:2]};
        rs1p = {CREG_BASE, i[9:7]};
        ci6  = {{26{i[12]}}, i[12], i[6:2]};
        outcome.next_pc = pc + 32'd2;

        case (i[1:0])
            Q0: begin
                case (f3)
                    F3_ADDI4SPN: begin
                        u = {22'd0, i[10:7], i[12:11], i[5], i[6], 2'b00};
                        if (u == '0) outcome.status = ST_UNHANDLED;
                        else record_write(rdp, xreg[REG_SP] + u);
                    end
                    F3_LW, F3_SW: begin
                        u = {25'd0, i[5], i[12:10], i[6], 2'b00};
                        outcome.mem_addr = xreg[rs1p] + u;
                        if (f3 == F3_LW) begin
                            outcome.mem_read = 1'b1;
                            load_busy = 1'b1;
                            load_rd   = rdp;
                        end else begin
                            outcome.mem_write = 1'b1;
                            outcome.mem_wdata = xreg[rdp];
                        end
                    end
                    default: outcome.status = ST_UNHANDLED;
                endcase
            end
            Q1: begin
                case (f3)
                    F3_ADDI: record_write(rdf, xreg[rdf] + ci6);
                    F3_JAL, F3_J: begin
                        v = {{20{i[12]}}, i[12], i[8], i[10:9], i[6], i[7], i[2], i[11],
                             i[5:3], 1'b0};
                        outcome.next_pc = pc + v;
                        if (f3 == F3_JAL) record_write(REG_RA, pc + 32'd2);
                    end
                    F3_LI: begin
                        if (rdf == REG_ZERO) outcome.status = ST_UNHANDLED;
                        else record_write(rdf, ci6);
                    end
                    F3_LUI: begin
                        if (rdf == REG_SP) begin
                            v = {{22{i[12]}}, i[12], i[4:3], i[5], i[2], i[6], 4'b0000};
                            if (v == '0) outcome.status = ST_UNHANDLED;
                            else record_write(REG_SP, xreg[REG_SP] + v);
                        end else if (rdf == REG_ZERO || (!i[12] && rs2f == '0)) begin
                            outcome.status = ST_UNHANDLED;
                        end else begin
                            record_write(rdf, ci6 << 12);
                        end
                    end
                    F3_MISC: begin
                        v = xreg[rs1p];
                        case (i[11:10])
                            FN2_SRLI, FN2_SRAI: begin
                                if (i[12] || rs2f == '0) begin
                                    outcome.status = ST_UNHANDLED;
                                end else begin
                                    // srai is a true arithmetic shift here
                                    if (i[11:10] == FN2_SRAI) w = $signed(v) >>> rs2f;
                                    else w = v >> rs2f;
                                    record_write(rs1p, w);
                                end
                            end
                            FN2_ANDI: record_write(rs1p, v & ci6);
                            default: begin
                                if (i[12]) begin
                                    outcome.status = ST_UNHANDLED;
                                end else begin
                                    w = xreg[rdp];
                                    case (i[6:5])
                                        AR_SUB:  record_write(rs1p, v - w);
                                        AR_XOR:  record_write(rs1p, v ^ w);
                                        AR_OR:   record_write(rs1p, v | w);
                                        default: record_write(rs1p, v & w);
                                    endcase
                                end
                            end
                        endcase
                    end
                    default: begin
                        // beqz / bnez
                        v = {{23{i[12]}}, i[12], i[6:5], i[2], i[11:10], i[4:3], 1'b0};
                        if ((xreg[rs1p] == '0) == (f3 == F3_BEQZ)) outcome.next_pc = pc + v;
                    end
                endcase
            end
            Q2: begin
                case (f3)
                    F3_SLLI: begin
                        if (rdf == REG_ZERO) outcome.status = ST_HINT;
                        else if (i[12]) outcome.status = ST_UNHANDLED;
                        else record_write(rdf, xreg[rdf] << rs2f);
                    end
                    F3_LWSP: begin
                        if (rdf == REG_ZERO) begin
                            outcome.status = ST_UNHANDLED;
                        end else begin
                            u = {24'd0, i[3:2], i[12], i[6:4], 2'b00};
                            outcome.mem_addr = xreg[REG_SP] + u;
                            outcome.mem_read = 1'b1;
                            load_busy = 1'b1;
                            load_rd   = rdf;
                        end
                    end
                    F3_JR: begin
                        if (rdf == REG_ZERO) begin
                            outcome.status = ST_UNHANDLED;
                        end else if (rs2f == REG_ZERO) begin
                            // jr / jalr: target read before the link write
                            v = xreg[rdf] & ~32'd1;
                            if (i[12]) record_write(REG_RA, pc + 32'd2);
                            outcome.next_pc = v;
                        end else if (!i[12]) begin
                            record_write(rdf, xreg[rs2f]);
                        end else begin
                            record_write(rdf, xreg[rdf] + xreg[rs2f]);
                        end
                    end
                    F3_SWSP: begin
                        u = {24'd0, i[8:7], i[12:9], 2'b00};
                        outcome.mem_addr  = xreg[REG_SP] + u;
                        outcome.mem_write = 1'b1;
                        outcome.mem_wdata = xreg[rs2f];
                    end
                    default: outcome.status = ST_UNHANDLED;
                endcase
            end
            default: outcome.status = ST_UNHANDLED;
        endcase
    endfunction

    task automatic check_field(input string what, input logic [XLEN-1:0] want,
                               input logic [XLEN-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s differs: expected %h, got %h", $realtime, what, want, got);
        end
    endtask

    // Result side first, then the new request
    always @(posedge i_clk) begin
        t_result got, want;
        t_item   req;
        if (!i_rst_n) begin
            foreach (xreg[k]) xreg[k] = '0;
            load_busy = 1'b0;
            load_rd   = '0;
            retire_queue.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.status    = i_res.status;
                got.next_pc   = i_res.next_pc;
                got.mem_read  = i_res.mem_read;
                got.mem_write = i_res.mem_write;
                got.mem_addr  = i_res.mem_addr;
                got.mem_wdata = i_res.mem_wdata;
                got.wb_enable = i_res.wb_enable;
                got.wb_index  = i_res.wb_index;
                got.wb_value  = i_res.wb_value;
                if (retire_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transfer with no request outstanding: %h",
                                 $realtime, got);
                end else begin
                    want = retire_queue.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("next_pc", want.next_pc, got.next_pc);
                    check_field("mem_read", want.mem_read, got.mem_read);
                    check_field("mem_write", want.mem_write, got.mem_write);
                    check_field("mem_addr", want.mem_addr, got.mem_addr);
                    check_field("mem_wdata", want.mem_wdata, got.mem_wdata);
                    check_field("wb_enable", want.wb_enable, got.wb_enable);
                    check_field("wb_index", want.wb_index, got.wb_index);
                    check_field("wb_value", want.wb_value, got.wb_value);
                end
            end
            if (i_req.valid && i_req.ready) begin
                req.req_type  = i_req.req_type;
                req.instr     = i_req.instr;
                req.pc        = i_req.pc;
                req.load_data = i_req.load_data;
                retire_item(req);
                retire_queue.push_back(outcome);
            end
        end
        o_mismatch_count <= mismatches;
        o_outstanding    <= retire_queue.size();
    end

endmodule

/* bench/rv32c_compressed_executor_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32c_compressed_executor_unit_test
// Drives the RV32C executor with a directed set of instructions (operand
// extremes, jumps, loads with data return and the illegal and hint forms),
// then with random, mostly well-formed instructions and load returns. Both
// channels idle at random; a separate check module predicts and compares.
// ----------------------------------------------------------------------------

module rv32c_compressed_executor_unit_test;

    import rvcexec_pkg::*;

    // funct3 codes of unimplemented quadrant 0 forms
    localparam logic [2:0] F3_FP_LOAD  = 3'b001;
    localparam logic [2:0] F3_Q0_RSVD  = 3'b100;
    localparam int         N_RANDOM    = 400;

    logic i_clk;
    logic i_rst_n;
    int   mismatch_count;
    int   outstanding;
    bit   req_calm = 1'b0;
    bit   res_calm = 1'b0;

    rvcexec_in_if  req_ch ();
    rvcexec_out_if res_ch ();

    rv32c_compressed_executor_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    rv32c_compressed_executor_unit_check result_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (req_ch),
        .i_res            (res_ch),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the handshake hangs
    initial begin
        #500us;
        $display("Mismatches found");
        $finish;
    end

    // Idle cycles per transfer; calm stretches switch on and off at random
    function automatic int idle_cycles(inout bit calm);
        if ($urandom_range(0, 31) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic logic [15:0] cword(input logic [2:0] f3, input logic b12,
                                          input logic [4:0] hi, input logic [4:0] lo,
                                          input logic [1:0] quad);
        return {f3, b12, hi, lo, quad};
    endfunction

    // One request transfer; valid stays high when no gap is drawn
    task automatic send_item(input t_item it);
        int gap;
        gap = idle_cycles(req_calm);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= it.req_type;
        req_ch.instr     <= it.instr;
        req_ch.pc        <= it.pc;
        req_ch.load_data <= it.load_data;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic run_instr(input logic [15:0] word, input logic [31:0] pc);
        send_item('{req_type: REQ_EXEC, instr: word, pc: pc, load_data: $urandom});
    endtask

    task automatic run_return(input logic [31:0] data);
        send_item('{req_type: REQ_LOAD_RET, instr: 16'($urandom), pc: $urandom,
                    load_data: data});
    endtask

    // Result side: random stalls, one transfer per draw
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = idle_cycles(res_calm);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    // Stimulus and verdict
    initial begin
        logic [15:0] bad_forms [14];
        logic [15:0] word;
        logic [10:0] body;
        logic [2:0]  op;
        logic [1:0]  quad;
        bit          loads_out;

        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= REQ_EXEC;
        req_ch.instr     <= '0;
        req_ch.pc        <= '0;
        req_ch.load_data <= '0;
        i_rst_n          <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // immediate extremes and register ops
        run_instr(cword(F3_LI, 1'b1, 5'd8, 5'd0, Q1), $urandom);
        run_instr(cword(F3_LUI, 1'b0, 5'd10, 5'd31, Q1), $urandom);
        run_instr(cword(F3_LUI, 1'b1, REG_SP, 5'd0, Q1), $urandom);
        run_instr(cword(F3_ADDI4SPN, 1'b1, 5'h1f, {2'b11, 3'd7}, Q0), $urandom);
        run_instr(cword(F3_MISC, 1'b0, {FN2_SRAI, 3'd0}, 5'd31, Q1), $urandom);
        // odd jump register target, bit 0 must be dropped
        run_instr(cword(F3_JR, 1'b0, 5'd8, REG_ZERO, Q2), $urandom);
        run_instr(cword(F3_MISC, 1'b0, {FN2_ARITH, 3'd2}, {AR_SUB, 3'd0}, Q1), $urandom);
        // loads: second one replaces the pending destination
        run_instr(cword(F3_LW, 1'b1, {2'b11, 3'd0}, {2'b11, 3'd4}, Q0), $urandom);
        run_instr(cword(F3_LWSP, 1'b1, 5'd31, 5'h1f, Q2), $urandom);
        run_return(32'hFFFF_FFFF);
        run_return(32'h0000_0000);
        run_instr(cword(F3_SWSP, 1'b1, 5'h1f, 5'd31, Q2), $urandom);
        // jumps and branches around the address wrap
        run_instr(cword(F3_JAL, 1'b1, 5'd0, 5'd0, Q1), 32'h0000_0000);
        run_instr(cword(F3_JR, 1'b1, REG_RA, REG_ZERO, Q2), $urandom);
        run_instr(cword(F3_J, 1'b0, 5'h1f, 5'h1f, Q1), 32'hFFFF_FFFE);
        run_instr(cword(F3_BEQZ, 1'b1, {2'b00, 3'd5}, 5'd0, Q1), $urandom);
        run_instr(cword(F3_BNEZ, 1'b0, {2'b11, 3'd5}, 5'h1f, Q1), $urandom);
        run_instr(cword(F3_JR, 1'b0, 5'd20, 5'd31, Q2), $urandom);
        run_instr(cword(F3_JR, 1'b1, 5'd20, 5'd8, Q2), $urandom);
        // addi to x0 is a no-op, slli to x0 is a bypassed hint
        run_instr(cword(F3_ADDI, 1'b1, REG_ZERO, 5'd1, Q1), $urandom);
        run_instr(cword(F3_SLLI, 1'b0, REG_ZERO, 5'd3, Q2), $urandom);

        // unhandled and illegal encodings
        bad_forms = '{
            16'h0000,                                               // addi4spn, zero imm
            16'hFFFF,                                               // quadrant 3
            cword(F3_JR, 1'b1, REG_ZERO, REG_ZERO, Q2),             // ebreak
            cword(F3_JR, 1'b0, REG_ZERO, REG_ZERO, Q2),             // jr x0
            cword(F3_JR, 1'b0, REG_ZERO, 5'd5, Q2),                 // mv to x0
            cword(F3_MISC, 1'b0, {FN2_SRLI, 3'd2}, 5'd0, Q1),       // srli by zero
            cword(F3_MISC, 1'b1, {FN2_SRAI, 3'd1}, 5'd3, Q1),       // shamt bit 5
            cword(F3_MISC, 1'b1, {FN2_ARITH, 3'd0}, {AR_SUB, 3'd1}, Q1), // subw
            cword(F3_LUI, 1'b0, REG_SP, 5'd0, Q1),                  // addi16sp, zero imm
            cword(F3_LUI, 1'b0, REG_ZERO, 5'd1, Q1),                // lui x0
            cword(F3_LI, 1'b0, REG_ZERO, 5'd7, Q1),                 // li x0
            cword(F3_LWSP, 1'b0, REG_ZERO, 5'd4, Q2),               // lwsp x0
            cword(F3_FP_LOAD, 1'b0, 5'd9, 5'd3, Q0),                // fld
            cword(F3_Q0_RSVD, 1'b1, 5'd9, 5'd3, Q0)                 // reserved
        };
        foreach (bad_forms[k]) run_instr(bad_forms[k], $urandom);

        // random part: mostly well-formed, some raw words
        loads_out = 1'b0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (loads_out ? ($urandom_range(0, 1) == 0) : ($urandom_range(0, 24) == 0)) begin
                run_return($urandom);
                loads_out = 1'b0;
            end else begin
                quad = 2'($urandom_range(0, 2));
                op   = 3'($urandom);
                body = 11'($urandom);
                if ($urandom_range(0, 7) != 0) begin
                    if (quad == Q0) begin
                        case ($urandom_range(0, 2))
                            0:       op = F3_ADDI4SPN;
                            1:       op = F3_LW;
                            default: op = F3_SW;
                        endcase
                    end else if (quad == Q2) begin
                        case ($urandom_range(0, 3))
                            0:       op = F3_SLLI;
                            1:       op = F3_LWSP;
                            2:       op = F3_JR;
                            default: op = F3_SWSP;
                        endcase
                    end
                end
                // body[10] is bit 12, body[9:8] the misc funct2, body[4:0] rs2
                if ($urandom_range(0, 3) != 0) begin
                    if (quad == Q1 && op == F3_MISC && body[9:8] != FN2_ANDI) body[10] = 1'b0;
                    if (quad == Q2 && op == F3_SLLI) body[10] = 1'b0;
                end
                if (quad == Q2 && op == F3_JR && $urandom_range(0, 2) == 0) body[4:0] = '0;
                word = {op, body, quad};
                if ($urandom_range(0, 9) == 0) word = 16'($urandom);
                if ((word[1:0] == Q0 && word[15:13] == F3_LW) ||
                    (word[1:0] == Q2 && word[15:13] == F3_LWSP && word[11:7] != REG_ZERO))
                    loads_out = 1'b1;
                run_instr(word, $urandom);
            end
        end
        req_ch.valid <= 1'b0;

        // drain, then keep watching for anything unexpected
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/rvcexec_pkg.sv
rtl/rvcexec_in_if.sv
rtl/rvcexec_out_if.sv
rtl/rvcexec_regfile.sv
rtl/rvcexec_exec.sv
rtl/rv32c_compressed_executor_unit.sv
bench/rv32c_compressed_executor_unit_check.sv
bench/rv32c_compressed_executor_unit_test.sv
